[design/read_write_reservation_table_unit_macros.svh]
// assertion macros for the reservation table unit
// used by the back end module; expects clk and rst in scope
`ifndef READ_WRITE_RESERVATION_TABLE_UNIT_MACROS_SVH
`define READ_WRITE_RESERVATION_TABLE_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define RWRT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rwrt assertion failed");

// next-cycle implication, off during reset
`define RWRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rwrt assertion failed");

`endif

[design/rwrt_pkg.sv]
// shared types and codes for the reservation table unit
// no dependencies
package rwrt_pkg;

  // input command codes
  localparam logic [1:0] CMD_RESERVE = 2'd0;
  localparam logic [1:0] CMD_ANALYZE = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  // hazard flag positions
  localparam int FLAG_WAW = 0;
  localparam int FLAG_WAR = 1;
  localparam int FLAG_RAW = 2;

  // operation carried through the queue
  typedef enum logic [1:0] {
    OP_RESERVE,
    OP_ANALYZE,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t  op;
    logic is_write;
    logic last;
  } ctl_t;

endpackage

[design/rwrt_queue.sv]
// two-entry item queue between front and back end
// no package dependencies
module rwrt_queue #(
  parameter int WIDTH = 46
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[design/rwrt_front.sv]
// front end: accepts input items, decodes the command, drops no-op items
// depends on rwrt_pkg
module rwrt_front #(
  parameter int KEY_BITS = 10,
  parameter int TXN_BITS = 32,
  parameter int ITEM_W   = 46
) (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          command,
  input  logic                is_write,
  input  logic [KEY_BITS-1:0] key_index,
  input  logic [TXN_BITS-1:0] txn_id,
  input  logic                last_in_set,
  input  logic                q_full,
  input  logic                sweeping,
  output logic                push,
  output logic [ITEM_W-1:0]   push_data
);

  rwrt_pkg::ctl_t ctl;
  logic           keep;

  always_comb begin
    ctl.is_write = is_write;
    ctl.last     = last_in_set;
    ctl.op       = rwrt_pkg::OP_RESERVE;
    keep         = 1'b0;
    unique case (command)
      rwrt_pkg::CMD_RESERVE: begin
        // a zero id would erase a reservation
        ctl.op = rwrt_pkg::OP_RESERVE;
        keep   = (txn_id != '0);
      end
      rwrt_pkg::CMD_ANALYZE: begin
        ctl.op = rwrt_pkg::OP_ANALYZE;
        keep   = 1'b1;
      end
      rwrt_pkg::CMD_CLEAR: begin
        ctl.op = rwrt_pkg::OP_CLEAR;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall  = q_full | sweeping;
  assign push      = in_valid & ~in_stall & keep;
  assign push_data = {ctl, key_index, txn_id};

endmodule

[design/rwrt_back.sv]
// back end: stamp memories, read-modify-write, flag collection, result register
// depends on rwrt_pkg and the assertion macro header
`include "read_write_reservation_table_unit_macros.svh"

module rwrt_back #(
  parameter int KEY_BITS = 10,
  parameter int TXN_BITS = 32,
  parameter int ITEM_W   = 46
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  logic [ITEM_W-1:0] q_data,
  output logic              q_pop,
  output logic              sweeping,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              waw_flag,
  output logic              war_flag,
  output logic              raw_flag
);

  localparam int CTL_W = $bits(rwrt_pkg::ctl_t);
  localparam int DEPTH = 1 << KEY_BITS;

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  logic [TXN_BITS-1:0] read_mem  [DEPTH];
  logic [TXN_BITS-1:0] write_mem [DEPTH];

  rwrt_pkg::ctl_t      q_ctl;
  logic [KEY_BITS-1:0] q_key;
  logic [TXN_BITS-1:0] q_txn;

  rwrt_pkg::ctl_t      cur_ctl;
  logic [KEY_BITS-1:0] cur_key;
  logic [TXN_BITS-1:0] cur_txn;
  logic [TXN_BITS-1:0] rd_stamp;
  logic [TXN_BITS-1:0] wr_stamp;
  logic [2:0]          pending;
  logic [KEY_BITS-1:0] sweep_addr;

  logic                older_rd;
  logic                older_wr;
  logic                lower_rd;
  logic                lower_wr;
  logic [2:0]          elem_flags;
  logic [2:0]          acc;
  logic                is_analyze;
  logic                out_free;
  logic                emit;
  logic                we_rd;
  logic                we_wr;
  logic [KEY_BITS-1:0] waddr;
  logic [TXN_BITS-1:0] wdata;

  assign q_ctl = rwrt_pkg::ctl_t'(q_data[ITEM_W-1 -: CTL_W]);
  assign q_key = q_data[TXN_BITS +: KEY_BITS];
  assign q_txn = q_data[TXN_BITS-1:0];

  assign sweeping = (state == S_SWEEP);
  assign q_pop    = (state == S_IDLE) && q_valid;

  // stamp compares on the registered read data
  assign older_rd = (rd_stamp != '0) && (cur_txn > rd_stamp);
  assign older_wr = (wr_stamp != '0) && (cur_txn > wr_stamp);
  assign lower_rd = (rd_stamp == '0) || (rd_stamp > cur_txn);
  assign lower_wr = (wr_stamp == '0) || (wr_stamp > cur_txn);

  always_comb begin
    elem_flags = 3'b000;
    if (cur_ctl.is_write) begin
      elem_flags[rwrt_pkg::FLAG_WAW] = older_wr;
      elem_flags[rwrt_pkg::FLAG_WAR] = older_rd;
    end else begin
      elem_flags[rwrt_pkg::FLAG_RAW] = older_wr;
    end
  end

  assign acc        = pending | elem_flags;
  assign is_analyze = (cur_ctl.op == rwrt_pkg::OP_ANALYZE);
  assign out_free   = ~out_valid | ~out_stall;
  assign emit       = (state == S_EXEC) && is_analyze && cur_ctl.last && out_free;

  // write port: clearing pass or stamp lowering
  assign we_rd = sweeping ||
                 ((state == S_EXEC) && (cur_ctl.op == rwrt_pkg::OP_RESERVE) &&
                  !cur_ctl.is_write && lower_rd);
  assign we_wr = sweeping ||
                 ((state == S_EXEC) && (cur_ctl.op == rwrt_pkg::OP_RESERVE) &&
                  cur_ctl.is_write && lower_wr);
  assign waddr = sweeping ? sweep_addr : cur_key;
  assign wdata = sweeping ? '0 : cur_txn;

  always_ff @(posedge clk) begin
    if (we_rd) begin
      read_mem[waddr] <= wdata;
    end
    if (we_wr) begin
      write_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_stamp <= read_mem[q_key];
      wr_stamp <= write_mem[q_key];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_addr <= '0;
      pending    <= 3'b000;
      out_valid  <= 1'b0;
    end else begin
      // result register: load on emit, drop once taken
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (&sweep_addr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cur_ctl <= q_ctl;
            cur_key <= q_key;
            cur_txn <= q_txn;
            if (q_ctl.op == rwrt_pkg::OP_CLEAR) begin
              state      <= S_SWEEP;
              sweep_addr <= '0;
              pending    <= 3'b000;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          if (!is_analyze) begin
            state <= S_IDLE;
          end else if (!cur_ctl.last) begin
            pending <= acc;
            state   <= S_IDLE;
          end else if (out_free) begin
            waw_flag  <= acc[rwrt_pkg::FLAG_WAW];
            war_flag  <= acc[rwrt_pkg::FLAG_WAR];
            raw_flag  <= acc[rwrt_pkg::FLAG_RAW];
            pending   <= 3'b000;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // no result can appear while the stores are being cleared
  `RWRT_ASSERT_NEXT(a_no_result_in_sweep, sweeping && !out_valid, !out_valid)
  // the memories are never written while waiting for an item
  `RWRT_ASSERT_NOW(a_no_write_in_idle, state == S_IDLE, !we_rd && !we_wr)
  // flags start fresh after a result goes out
  `RWRT_ASSERT_NEXT(a_pending_cleared, emit, pending == 3'b000 && out_valid)
  // a reserve finishes in its execute cycle
  `RWRT_ASSERT_NEXT(a_reserve_done, state == S_EXEC && !is_analyze, state == S_IDLE)

endmodule

[design/read_write_reservation_table_unit.sv]
// Reservation table for deterministic concurrency control. Each key index
// has a read stamp and a write stamp holding the smallest transaction id
// that reserved it this epoch (zero is empty). A reserve item lowers the
// stamp, an analyze item collects waw/war/raw hazards over the transaction's
// set and reports them on the item marked last, and a clear item empties
// both stores. In the back end a reserve or analyze item is read from the
// stamp memory in the idle state and compared and written back in the
// execute state; the back end takes no new item until it is through with
// the current one. Unused commands and zero-id reserves are taken by the
// front end and dropped. After reset and after each clear item the back
// end runs a clearing pass over all 2**KEY_BITS entries of the stores (1024
// with the default key width), one entry per cycle, while input is stalled.
// depends on rwrt_pkg, rwrt_front, rwrt_queue, rwrt_back
module read_write_reservation_table_unit #(
  parameter int KEY_BITS = 10,
  parameter int TXN_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  // input item channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          command,
  input  logic                is_write,
  input  logic [KEY_BITS-1:0] key_index,
  input  logic [TXN_BITS-1:0] txn_id,
  input  logic                last_in_set,
  // result item channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                waw_flag,
  output logic                war_flag,
  output logic                raw_flag
);

  // queued item: control bits, key, id
  localparam int ITEM_W = $bits(rwrt_pkg::ctl_t) + KEY_BITS + TXN_BITS;

  logic              push;
  logic [ITEM_W-1:0] push_data;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic [ITEM_W-1:0] q_data;
  logic              sweeping;

  // front end: decode and drop no-op items
  rwrt_front #(
    .KEY_BITS (KEY_BITS),
    .TXN_BITS (TXN_BITS),
    .ITEM_W   (ITEM_W)
  ) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .is_write    (is_write),
    .key_index   (key_index),
    .txn_id      (txn_id),
    .last_in_set (last_in_set),
    .q_full      (q_full),
    .sweeping    (sweeping),
    .push        (push),
    .push_data   (push_data)
  );

  // short queue so the front keeps taking items while the back works
  rwrt_queue #(
    .WIDTH (ITEM_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  // back end: stamp memories and result register
  rwrt_back #(
    .KEY_BITS (KEY_BITS),
    .TXN_BITS (TXN_BITS),
    .ITEM_W   (ITEM_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .sweeping  (sweeping),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .waw_flag  (waw_flag),
    .war_flag  (war_flag),
    .raw_flag  (raw_flag)
  );

endmodule

[sim/read_write_reservation_table_checker.sv]
// scoreboard for the reservation table unit: keeps its own read and write
// stamps, predicts the hazard flags of each finished set and checks results
// depends on rwrt_pkg
module read_write_reservation_table_checker
  import rwrt_pkg::*;
#(
  parameter int KEY_BITS = 10,
  parameter int TXN_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [1:0]          command,
  input  logic                is_write,
  input  logic [KEY_BITS-1:0] key_index,
  input  logic [TXN_BITS-1:0] txn_id,
  input  logic                last_in_set,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic                waw_flag,
  input  logic                war_flag,
  input  logic                raw_flag,
  output int                  mismatch_count,
  output int                  pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_DEPTH = 1 << KEY_BITS;

  typedef struct packed {
    logic waw;
    logic war;
    logic raw;
  } hazard_t;

  logic [TXN_BITS-1:0] rd_stamp [KEY_DEPTH];
  logic [TXN_BITS-1:0] wr_stamp [KEY_DEPTH];
  logic [2:0]          set_flags;
  hazard_t             hazard_queue [$];

  // nonzero stamp owned by an earlier transaction
  function automatic logic held_earlier(input logic [TXN_BITS-1:0] stamp,
                                        input logic [TXN_BITS-1:0] id);
    return (stamp != '0) && (id > stamp);
  endfunction

  function automatic logic [TXN_BITS-1:0] lowered(input logic [TXN_BITS-1:0] stamp,
                                                  input logic [TXN_BITS-1:0] id);
    return (stamp == '0 || stamp > id) ? id : stamp;
  endfunction

  task automatic report_mismatch(input string what, input logic want, input logic got);
    $display("%0t: %s: expected %0b, got %0b", $realtime, what, want, got);
    mismatch_count++;
  endtask

  // apply one accepted item to the shadow stamps
  task automatic track_item(input logic [1:0] cmd, input logic wr,
                            input logic [KEY_BITS-1:0] key,
                            input logic [TXN_BITS-1:0] id, input logic last);
    hazard_t flags;
    case (cmd)
      CMD_CLEAR: begin
        for (int k = 0; k < KEY_DEPTH; k++) begin
          rd_stamp[k] = '0;
          wr_stamp[k] = '0;
        end
        set_flags = '0;
      end
      CMD_RESERVE: begin
        if (id != '0) begin
          if (wr) wr_stamp[key] = lowered(wr_stamp[key], id);
          else rd_stamp[key] = lowered(rd_stamp[key], id);
        end
      end
      CMD_ANALYZE: begin
        if (wr) begin
          if (held_earlier(wr_stamp[key], id)) set_flags[FLAG_WAW] = 1'b1;
          if (held_earlier(rd_stamp[key], id)) set_flags[FLAG_WAR] = 1'b1;
        end else if (held_earlier(wr_stamp[key], id)) begin
          set_flags[FLAG_RAW] = 1'b1;
        end
        if (last) begin
          flags.waw = set_flags[FLAG_WAW];
          flags.war = set_flags[FLAG_WAR];
          flags.raw = set_flags[FLAG_RAW];
          hazard_queue.push_back(flags);
          set_flags = '0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    hazard_t want;
    if (rst) begin
      track_item(CMD_CLEAR, 1'b0, '0, '0, 1'b0);
      hazard_queue.delete();
      mismatch_count = 0;
    end else begin
      // results first: a result never belongs to an item taken at the same edge
      if (out_valid && !out_stall) begin
        if (hazard_queue.size() == 0) begin
          report_mismatch("result with nothing expected", 1'b0, 1'b1);
        end else begin
          want = hazard_queue.pop_front();
          if (waw_flag !== want.waw) report_mismatch("waw_flag", want.waw, waw_flag);
          if (war_flag !== want.war) report_mismatch("war_flag", want.war, war_flag);
          if (raw_flag !== want.raw) report_mismatch("raw_flag", want.raw, raw_flag);
        end
      end
      if (in_valid && !in_stall)
        track_item(command, is_write, key_index, txn_id, last_in_set);
    end
    pending_results <= hazard_queue.size();
  end

endmodule

[sim/testbench.sv]
// top of the reservation table unit testbench: clock, reset, stimulus,
// result-side back pressure and the final verdict
// depends on rwrt_pkg, read_write_reservation_table_unit and the checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rwrt_pkg::*;

  localparam int KEY_BITS    = 10;
  localparam int TXN_BITS    = 32;
  localparam int KEY_DEPTH   = 1 << KEY_BITS;
  localparam int ITEM_TARGET = 1800;
  // command code the block drops without effect
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          command = CMD_RESERVE;
  logic                is_write = 1'b0;
  logic [KEY_BITS-1:0] key_index = '0;
  logic [TXN_BITS-1:0] txn_id = '0;
  logic                last_in_set = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                waw_flag;
  logic                war_flag;
  logic                raw_flag;

  int mismatch_count;
  int pending_results;

  // idling mix: phase 0 sender light / receiver heavy, phase 1 swapped,
  // phase 2 no random idling (plus one long receiver hold-off)
  int idle_phase    = 0;
  int send_idle_pct = 16;
  int recv_idle_pct = 65;
  int items_done    = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;

  always #2 clk = ~clk;

  read_write_reservation_table_unit #(
    .KEY_BITS(KEY_BITS),
    .TXN_BITS(TXN_BITS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .is_write   (is_write),
    .key_index  (key_index),
    .txn_id     (txn_id),
    .last_in_set(last_in_set),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .waw_flag   (waw_flag),
    .war_flag   (war_flag),
    .raw_flag   (raw_flag)
  );

  read_write_reservation_table_checker #(
    .KEY_BITS(KEY_BITS),
    .TXN_BITS(TXN_BITS)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .is_write       (is_write),
    .key_index      (key_index),
    .txn_id         (txn_id),
    .last_in_set    (last_in_set),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .waw_flag       (waw_flag),
    .war_flag       (war_flag),
    .raw_flag       (raw_flag),
    .mismatch_count (mismatch_count),
    .pending_results(pending_results)
  );

  // mostly a handful of hot keys so stamps collide, sometimes the full range
  function automatic logic [KEY_BITS-1:0] pick_key();
    if ($urandom_range(99) < 85) return KEY_BITS'($urandom_range(0, 7));
    return KEY_BITS'($urandom_range(0, KEY_DEPTH - 1));
  endfunction

  // small ids give ordering conflicts, wide ones exercise every bit,
  // and now and then a zero id
  function automatic logic [TXN_BITS-1:0] pick_txn();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return TXN_BITS'($urandom_range(1, 16));
    if (roll < 95) return TXN_BITS'($urandom);
    return '0;
  endfunction

  // offer one item, with a random lead-in gap, and hold it until taken
  task automatic send_item(input logic [1:0] cmd, input logic wr,
                           input logic [KEY_BITS-1:0] key,
                           input logic [TXN_BITS-1:0] id, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    is_write    <= wr;
    key_index   <= key;
    txn_id      <= id;
    last_in_set <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // dropped items (unused command, zero-id reserve) do not count
    if (cmd == CMD_ANALYZE || cmd == CMD_CLEAR || (cmd == CMD_RESERVE && id != '0))
      items_done++;
  endtask

  // receiver side: random stalls per phase, one long hold-off when the
  // no-idle phase begins so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (idle_phase == 2 && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    logic [KEY_BITS-1:0] set_keys [6][4];
    logic                set_wr   [6][4];
    logic [TXN_BITS-1:0] set_ids  [6];
    int                  set_size [6];
    int                  n_txn;
    int                  roll;
    int                  burst;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: extreme ids and keys, stamp lowering, ignored fields
    send_item(CMD_CLEAR, 1'b1, '1, '1, 1'b1);
    send_item(CMD_RESERVE, 1'b1, 10'd0, 32'hFFFF_FFFF, 1'b0);
    send_item(CMD_RESERVE, 1'b1, 10'd0, 32'd5, 1'b0);        // lowers the write stamp
    send_item(CMD_RESERVE, 1'b1, 10'd0, 32'd9, 1'b0);        // larger id, no change
    send_item(CMD_RESERVE, 1'b0, 10'd1023, 32'd1, 1'b0);
    send_item(CMD_RESERVE, 1'b0, 10'd1023, 32'd0, 1'b0);     // zero id must not erase
    send_item(CMD_RESERVE, 1'b1, 10'd1023, 32'd3, 1'b1);     // last ignored on reserve
    send_item(CMD_UNUSED, 1'b1, '1, '1, 1'b1);               // dropped entirely
    send_item(CMD_ANALYZE, 1'b1, 10'd0, 32'd5, 1'b1);        // own stamp, no hazard
    send_item(CMD_ANALYZE, 1'b1, 10'd0, 32'd6, 1'b0);        // waw
    send_item(CMD_ANALYZE, 1'b0, 10'd1023, 32'hFFFF_FFFF, 1'b0); // raw
    send_item(CMD_ANALYZE, 1'b1, 10'd1023, 32'd2, 1'b1);     // war, set closes
    send_item(CMD_ANALYZE, 1'b0, 10'd1023, 32'd0, 1'b1);     // zero id raises nothing
    send_item(CMD_ANALYZE, 1'b1, 10'd512, 32'd1, 1'b1);      // empty key
    send_item(CMD_ANALYZE, 1'b0, 10'd0, 32'hFFFF_FFFF, 1'b0); // raw left pending
    send_item(CMD_CLEAR, 1'b0, '0, '0, 1'b0);                // clear drops pending flags
    send_item(CMD_ANALYZE, 1'b1, 10'd0, 32'hFFFF_FFFF, 1'b1);
    send_item(CMD_RESERVE, 1'b0, 10'd341, 32'hAAAA_AAAA, 1'b1);
    send_item(CMD_RESERVE, 1'b0, 10'd682, 32'h5555_5555, 1'b0);
    send_item(CMD_ANALYZE, 1'b1, 10'd341, 32'hAAAA_AAAB, 1'b1);
    send_item(CMD_ANALYZE, 1'b0, 10'd682, 32'h5555_5556, 1'b1); // read vs read, nothing

    while (items_done < ITEM_TARGET) begin
      // idling phase follows progress through the random part
      if (items_done >= 2 * ITEM_TARGET / 3 && idle_phase != 2) begin
        idle_phase    <= 2;
        send_idle_pct  = 0;
        recv_idle_pct <= 0;
      end else if (items_done >= ITEM_TARGET / 3 && idle_phase == 0) begin
        idle_phase    <= 1;
        send_idle_pct  = 65;
        recv_idle_pct <= 16;
      end

      roll = $urandom_range(99);
      if (roll < 80) begin
        // well-formed epoch: every transaction reserves its set, then each
        // analyzes it with the final element marked last
        if ($urandom_range(99) < 25)
          send_item(CMD_CLEAR, 1'($urandom), pick_key(), pick_txn(), 1'($urandom));
        n_txn = $urandom_range(1, 6);
        for (int t = 0; t < n_txn; t++) begin
          set_ids[t]  = pick_txn();
          set_size[t] = $urandom_range(1, 4);
          for (int e = 0; e < set_size[t]; e++) begin
            set_keys[t][e] = pick_key();
            set_wr[t][e]   = 1'($urandom);
          end
        end
        for (int t = 0; t < n_txn; t++)
          for (int e = 0; e < set_size[t]; e++)
            send_item(CMD_RESERVE, set_wr[t][e], set_keys[t][e], set_ids[t],
                      1'($urandom));
        for (int t = 0; t < n_txn; t++)
          for (int e = 0; e < set_size[t]; e++)
            send_item(CMD_ANALYZE, set_wr[t][e], set_keys[t][e], set_ids[t],
                      e == set_size[t] - 1);
      end else if (roll < 90) begin
        // noise: any command with any field values
        burst = $urandom_range(1, 4);
        repeat (burst)
          send_item(2'($urandom_range(0, 3)), 1'($urandom), pick_key(), pick_txn(),
                    1'($urandom));
      end else begin
        // broken set: analyze elements with no reserve phase, last rarely set,
        // sometimes cut short by a clear
        burst = $urandom_range(1, 5);
        repeat (burst) begin
          if ($urandom_range(99) < 10)
            send_item(CMD_CLEAR, 1'($urandom), pick_key(), pick_txn(), 1'($urandom));
          else
            send_item(CMD_ANALYZE, 1'($urandom), pick_key(), pick_txn(),
                      $urandom_range(99) < 25);
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    // drain window for any stray result
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog, well beyond the slowest correct run including clearing passes
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[read_write_reservation_table_unit.f]
+incdir+design
design/rwrt_pkg.sv
design/rwrt_queue.sv
design/rwrt_front.sv
design/rwrt_back.sv
design/read_write_reservation_table_unit.sv
sim/read_write_reservation_table_checker.sv
sim/testbench.sv
